### hdl/pcdst_pkg.sv
// shared types, codes and constants for the pan/crop dirty strip tracker
package pcdst_pkg;

    // default geometry
    localparam int CROP_WIDTH_DEF    = 240;
    localparam int CROP_HEIGHT_DEF   = 135;
    localparam int SOURCE_WIDTH_DEF  = 512;
    localparam int SOURCE_HEIGHT_DEF = 342;
    localparam int STRIP_HEIGHT_DEF  = 5;

    // fixed field widths
    localparam int MASK_BITS   = 27;
    localparam int STRIP_IDX_W = 5;
    localparam int MARGIN_W    = 7;
    localparam int COORD_W     = 12;

    // margin reset values
    localparam logic [MARGIN_W-1:0] MARGIN_X_RST = 7'd60;
    localparam logic [MARGIN_W-1:0] MARGIN_Y_RST = 7'd33;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [8:0]                t_view_x;
    typedef logic [7:0]                t_view_y;
    typedef logic [MASK_BITS-1:0]      t_mask;

    typedef enum logic {
        FUNC_FRAME = 1'b0,
        FUNC_PIXEL = 1'b1
    } t_func;

    typedef enum logic {
        KIND_VIEW  = 1'b0,
        KIND_DIRTY = 1'b1
    } t_kind;

    typedef enum logic {
        CFG_MARGIN_X = 1'b0,
        CFG_MARGIN_Y = 1'b1
    } t_cfg_reg;

    // one operation handed from the front stage to the commit stage
    typedef struct packed {
        logic                   valid;
        logic                   fs;        // frame start: reload moved flag and dirty bits
        logic                   moved;
        logic                   wr;        // crop byte inside the window
        logic                   rpt;       // emits a report when it commits
        t_kind                  kind;
        logic [7:0]             value;
        logic                   strip_ok;
        logic [STRIP_IDX_W-1:0] strip;
        t_view_x                view_x;
        t_view_y                view_y;
    } t_op;

endpackage

### hdl/pcdst_shadow.sv
// shadow byte memory with clearing pass after reset and read bypass
module pcdst_shadow #(
    parameter int DEPTH  = 4050,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    output logic              o_clr_busy
);

    logic [7:0]        r_shadow [DEPTH];
    logic [7:0]        r_rd;
    logic              r_byp;
    logic [7:0]        r_byp_data;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [7:0]        wd;

    always_comb begin
        we = i_wr_en;
        wa = i_wr_addr;
        wd = i_wr_data;
        if (r_clr_busy) begin
            we = 1'b1;
            wa = r_clr_addr;
            wd = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_shadow[wa] <= wd;
        end
        if (i_rd_en) begin
            r_rd <= r_shadow[i_rd_addr];
        end
    end

    // same-cycle write to the address being read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_byp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data  = r_byp ? r_byp_data : r_rd;
    assign o_clr_busy = r_clr_busy;

endmodule

### hdl/pcdst_front.sv
// front stage: pan update, funnel shift and crop position of each byte
module pcdst_front #(
    parameter int CROP_WIDTH    = pcdst_pkg::CROP_WIDTH_DEF,
    parameter int CROP_HEIGHT   = pcdst_pkg::CROP_HEIGHT_DEF,
    parameter int SOURCE_WIDTH  = pcdst_pkg::SOURCE_WIDTH_DEF,
    parameter int SOURCE_HEIGHT = pcdst_pkg::SOURCE_HEIGHT_DEF,
    parameter int STRIP_HEIGHT  = pcdst_pkg::STRIP_HEIGHT_DEF,
    parameter int POS_W         = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_func,
    input  logic [8:0]                       i_pointer_x,
    input  logic [8:0]                       i_pointer_y,
    input  logic [7:0]                       i_pixel_byte,
    input  logic [8:0]                       i_src_row,
    input  logic [5:0]                       i_src_col,
    input  logic [pcdst_pkg::MARGIN_W-1:0]   i_margin_x,
    input  logic [pcdst_pkg::MARGIN_W-1:0]   i_margin_y,
    input  logic                             i_adv,
    input  logic                             i_clr_busy,
    output pcdst_pkg::t_op                   o_op,
    output logic [POS_W-1:0]                 o_pos,
    output logic                             o_rd_en
);

    localparam int ROW_BYTES   = CROP_WIDTH / 8;
    localparam int SRC_STRIDE  = SOURCE_WIDTH / 8;
    localparam int X_HI        = (SOURCE_WIDTH > CROP_WIDTH) ? SOURCE_WIDTH - CROP_WIDTH : 0;
    localparam int Y_HI        = (SOURCE_HEIGHT > CROP_HEIGHT) ? SOURCE_HEIGHT - CROP_HEIGHT : 0;
    localparam int VX_W        = $clog2(SOURCE_WIDTH);
    localparam int VY_W        = $clog2(SOURCE_HEIGHT + 1);
    localparam int PY_W        = (CROP_HEIGHT > 1) ? $clog2(CROP_HEIGHT) : 1;
    localparam int IDX_W       = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;
    localparam int RECIP_SH    = 16;
    localparam int STRIP_RECIP = ((1 << RECIP_SH) + STRIP_HEIGHT - 1) / STRIP_HEIGHT;
    localparam int PROD_W      = PY_W + RECIP_SH + 1;

    // ease about halfway toward the margin target, clamped to [0, hi]
    function automatic pcdst_pkg::t_coord pan_axis(
        input pcdst_pkg::t_coord cur,
        input pcdst_pkg::t_coord ptr,
        input pcdst_pkg::t_coord margin,
        input pcdst_pkg::t_coord size,
        input pcdst_pkg::t_coord hi
    );
        pcdst_pkg::t_coord target;
        pcdst_pkg::t_coord delta;
        pcdst_pkg::t_coord res;
        target = cur;
        if (ptr < cur + margin) begin
            target = ptr - margin;
        end else if (ptr >= cur + size - margin) begin
            target = ptr - (size - margin);
        end
        if (target < 0) begin
            target = '0;
        end
        if (target > hi) begin
            target = hi;
        end
        delta = target - cur;
        res   = cur;
        if (delta > 0) begin
            res = cur + ((delta + 1) >>> 1);
        end else if (delta < 0) begin
            res = cur - ((-delta + 1) >>> 1);
        end
        return res;
    endfunction

    logic [VX_W-1:0]   r_view_x;
    logic [VY_W-1:0]   r_view_y;
    logic              r_first;
    logic [7:0]        r_prior;
    logic              r_sec_valid;
    pcdst_pkg::t_coord r_sec_py;
    pcdst_pkg::t_coord r_sec_idx;
    logic [7:0]        r_sec_value;
    logic              r_sec_rpt;

    logic              accept;
    logic              is_frame;
    logic              in_range;
    logic              last_col;
    logic              byte_rpt;
    logic              dual;
    logic              byte_take;
    logic [2:0]        shift;
    pcdst_pkg::t_coord off;
    pcdst_pkg::t_coord cur_x;
    pcdst_pkg::t_coord cur_y;
    pcdst_pkg::t_coord nx;
    pcdst_pkg::t_coord ny;
    logic              moved;
    logic [15:0]       funnel;
    logic [15:0]       tail;
    pcdst_pkg::t_coord byte_py;
    pcdst_pkg::t_coord byte_col;
    pcdst_pkg::t_coord byte_idx;
    logic              put;
    pcdst_pkg::t_coord sel_py;
    pcdst_pkg::t_coord sel_idx;
    logic [7:0]        sel_value;
    logic              sel_rpt;
    logic              in_win;
    logic [PY_W-1:0]   py_u;
    logic [IDX_W-1:0]  idx_u;
    logic [PROD_W-1:0] strip_prod;
    logic [PY_W:0]     strip_full;

    assign o_in_ready = !i_clr_busy && i_adv && !r_sec_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign is_frame   = (i_func == pcdst_pkg::FUNC_FRAME);
    assign in_range   = (pcdst_pkg::t_coord'(i_src_row) < pcdst_pkg::t_coord'(SOURCE_HEIGHT))
                     && (pcdst_pkg::t_coord'(i_src_col) < pcdst_pkg::t_coord'(SRC_STRIDE));
    assign last_col   = pcdst_pkg::t_coord'(i_src_col) == pcdst_pkg::t_coord'(SRC_STRIDE - 1);
    assign byte_rpt   = last_col
                     && (pcdst_pkg::t_coord'(i_src_row) == pcdst_pkg::t_coord'(SOURCE_HEIGHT - 1));
    assign shift      = r_view_x[2:0];
    assign off        = pcdst_pkg::t_coord'(r_view_x >> 3);
    assign cur_x      = pcdst_pkg::t_coord'(r_view_x);
    assign cur_y      = pcdst_pkg::t_coord'(r_view_y);
    assign dual       = (shift != 3'd0) && last_col;
    assign byte_take  = accept && !is_frame && in_range;

    assign nx = pan_axis(cur_x, pcdst_pkg::t_coord'(i_pointer_x),
                         pcdst_pkg::t_coord'(i_margin_x),
                         pcdst_pkg::t_coord'(CROP_WIDTH), pcdst_pkg::t_coord'(X_HI));
    assign ny = pan_axis(cur_y, pcdst_pkg::t_coord'(i_pointer_y),
                         pcdst_pkg::t_coord'(i_margin_y),
                         pcdst_pkg::t_coord'(CROP_HEIGHT), pcdst_pkg::t_coord'(Y_HI));
    assign moved = r_first || (nx != cur_x) || (ny != cur_y);

    // funnel shift: prior byte and current byte, and the zero-filled tail
    assign funnel   = {r_prior, i_pixel_byte} << shift;
    assign tail     = {i_pixel_byte, 8'd0} << shift;
    assign byte_py  = pcdst_pkg::t_coord'(i_src_row) - cur_y;
    assign byte_col = pcdst_pkg::t_coord'(i_src_col);
    assign byte_idx = (shift == 3'd0) ? byte_col - off : byte_col - off - 1;

    always_comb begin
        put       = 1'b0;
        sel_py    = byte_py;
        sel_idx   = byte_idx;
        sel_value = (shift == 3'd0) ? i_pixel_byte : funnel[15:8];
        sel_rpt   = byte_rpt && !dual;
        if (r_sec_valid) begin
            put       = i_adv;
            sel_py    = r_sec_py;
            sel_idx   = r_sec_idx;
            sel_value = r_sec_value;
            sel_rpt   = r_sec_rpt;
        end else if (byte_take) begin
            put = 1'b1;
        end
    end

    assign in_win = (sel_py >= 0) && (sel_py < pcdst_pkg::t_coord'(CROP_HEIGHT))
                 && (sel_idx >= 0) && (sel_idx < pcdst_pkg::t_coord'(ROW_BYTES));
    assign py_u   = sel_py[PY_W-1:0];
    assign idx_u  = sel_idx[IDX_W-1:0];
    assign o_pos  = POS_W'(py_u) * POS_W'(ROW_BYTES) + POS_W'(idx_u);

    // strip = row / STRIP_HEIGHT by reciprocal, exact for the row range
    assign strip_prod = PROD_W'(py_u) * PROD_W'(STRIP_RECIP);
    assign strip_full = strip_prod[PROD_W-1:RECIP_SH];

    always_comb begin
        o_op = '0;
        if (put) begin
            o_op.valid    = 1'b1;
            o_op.wr       = in_win;
            o_op.rpt      = sel_rpt;
            o_op.kind     = pcdst_pkg::KIND_DIRTY;
            o_op.value    = sel_value;
            o_op.strip_ok = strip_full < (PY_W + 1)'(pcdst_pkg::MASK_BITS);
            o_op.strip    = strip_full[pcdst_pkg::STRIP_IDX_W-1:0];
            o_op.view_x   = pcdst_pkg::t_view_x'(r_view_x);
            o_op.view_y   = pcdst_pkg::t_view_y'(r_view_y);
        end else if (accept && is_frame) begin
            o_op.valid  = 1'b1;
            o_op.fs     = 1'b1;
            o_op.moved  = moved;
            o_op.rpt    = 1'b1;
            o_op.kind   = pcdst_pkg::KIND_VIEW;
            o_op.view_x = pcdst_pkg::t_view_x'(nx);
            o_op.view_y = pcdst_pkg::t_view_y'(ny);
        end
    end

    assign o_rd_en = o_op.valid && o_op.wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_x    <= '0;
            r_view_y    <= '0;
            r_first     <= 1'b1;
            r_prior     <= '0;
            r_sec_valid <= 1'b0;
        end else begin
            if (accept && is_frame) begin
                r_view_x <= VX_W'(nx);
                r_view_y <= VY_W'(ny);
            end
            if (r_sec_valid && i_adv) begin
                r_sec_valid <= 1'b0;
            end
            if (byte_take) begin
                r_prior <= i_pixel_byte;
                if (byte_rpt) begin
                    r_first <= 1'b0;
                end
                if (dual) begin
                    r_sec_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (byte_take && dual) begin
            r_sec_py    <= byte_py;
            r_sec_idx   <= byte_col - off;
            r_sec_value <= tail[15:8];
            r_sec_rpt   <= byte_rpt;
        end
    end

endmodule

### hdl/pcdst_commit.sv
// commit stage: compare with shadow, write back, accumulate strips, result register
module pcdst_commit #(
    parameter int CROP_HEIGHT  = pcdst_pkg::CROP_HEIGHT_DEF,
    parameter int STRIP_HEIGHT = pcdst_pkg::STRIP_HEIGHT_DEF,
    parameter int POS_W        = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  pcdst_pkg::t_op            i_op,
    input  logic [POS_W-1:0]          i_pos,
    input  logic [7:0]                i_rd_data,
    output logic                      o_adv,
    output logic                      o_wr_en,
    output logic [POS_W-1:0]          o_wr_addr,
    output logic [7:0]                o_wr_data,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic                      o_kind,
    output logic [8:0]                o_view_x,
    output logic [7:0]                o_view_y,
    output logic [pcdst_pkg::MASK_BITS-1:0] o_dirty_mask
);

    localparam int STRIP_COUNT = (CROP_HEIGHT + STRIP_HEIGHT - 1) / STRIP_HEIGHT;
    localparam pcdst_pkg::t_mask ALL_STRIPS = (STRIP_COUNT >= pcdst_pkg::MASK_BITS) ? '1 :
        pcdst_pkg::t_mask'((64'd1 << STRIP_COUNT) - 64'd1);

    pcdst_pkg::t_op    r_b;
    logic [POS_W-1:0]  r_b_pos;
    logic              r_moved;
    pcdst_pkg::t_mask  r_dirty;
    logic              r_out_valid;
    pcdst_pkg::t_kind  r_out_kind;
    pcdst_pkg::t_view_x r_out_x;
    pcdst_pkg::t_view_y r_out_y;
    pcdst_pkg::t_mask  r_out_mask;

    logic              hit;
    pcdst_pkg::t_mask  dirty_now;
    logic              emit;

    // a report waits here while the result register is still occupied
    assign o_adv = !(r_b.valid && r_b.rpt && r_out_valid && !i_out_ready);
    assign emit  = o_adv && r_b.valid && r_b.rpt;

    assign hit       = r_b.valid && r_b.wr && !r_moved && r_b.strip_ok
                    && (i_rd_data != r_b.value);
    assign dirty_now = hit ? (r_dirty | (pcdst_pkg::t_mask'(1) << r_b.strip)) : r_dirty;

    assign o_wr_en   = o_adv && r_b.valid && r_b.wr;
    assign o_wr_addr = r_b_pos;
    assign o_wr_data = r_b.value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b     <= '0;
            r_moved <= 1'b0;
            r_dirty <= '0;
        end else if (o_adv) begin
            r_b <= i_op;
            // a frame start entering now is younger than the op committing now
            if (i_op.valid && i_op.fs) begin
                r_moved <= i_op.moved;
                r_dirty <= i_op.moved ? ALL_STRIPS : '0;
            end else begin
                r_dirty <= dirty_now;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_b_pos <= i_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind <= r_b.kind;
            r_out_x    <= r_b.view_x;
            r_out_y    <= r_b.view_y;
            r_out_mask <= (r_b.kind == pcdst_pkg::KIND_DIRTY) ? dirty_now : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_view_x     = r_out_x;
    assign o_view_y     = r_out_y;
    assign o_dirty_mask = r_out_mask;

endmodule

### hdl/pan_crop_dirty_strip_tracker_core.sv
// top level of the pan/crop dirty strip tracker
//
//   channel   direction  handshake                   payload
//   input     in         i_in_valid / o_in_ready     func, pointer_x/y, pixel_byte, src_row/col
//   result    out        o_out_valid / i_out_ready   kind, view_x, view_y, dirty_mask
//   config    in         i_cfg_valid / o_cfg_ready   cfg_index, cfg_data
//
// one transfer per cycle unless stalled; a byte at the last source column with a nonzero
// fine shift holds off the next transfer, as it writes two crop bytes through the single
// shadow write port; o_out_valid rises once the result has passed the commit register and
// the result register, and the report of such a byte comes with its second crop byte
// after reset the shadow memory is cleared, one entry a cycle (4050 entries by default,
// CROP_WIDTH/8 * CROP_HEIGHT in general); config transfers are taken meanwhile
// a report held in the commit stage behind a full result register stalls the input
module pan_crop_dirty_strip_tracker_core #(
    parameter int CROP_WIDTH    = pcdst_pkg::CROP_WIDTH_DEF,
    parameter int CROP_HEIGHT   = pcdst_pkg::CROP_HEIGHT_DEF,
    parameter int SOURCE_WIDTH  = pcdst_pkg::SOURCE_WIDTH_DEF,
    parameter int SOURCE_HEIGHT = pcdst_pkg::SOURCE_HEIGHT_DEF,
    parameter int STRIP_HEIGHT  = pcdst_pkg::STRIP_HEIGHT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input items
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_func,
    input  logic [8:0]                        i_pointer_x,
    input  logic [8:0]                        i_pointer_y,
    input  logic [7:0]                        i_pixel_byte,
    input  logic [8:0]                        i_src_row,
    input  logic [5:0]                        i_src_col,
    // result items
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_kind,
    output logic [8:0]                        o_view_x,
    output logic [7:0]                        o_view_y,
    output logic [pcdst_pkg::MASK_BITS-1:0]   o_dirty_mask,
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic                              i_cfg_index,
    input  logic [pcdst_pkg::MARGIN_W-1:0]    i_cfg_data
);

    localparam int SHADOW_DEPTH = (CROP_WIDTH / 8) * CROP_HEIGHT;
    localparam int POS_W        = (SHADOW_DEPTH > 1) ? $clog2(SHADOW_DEPTH) : 1;

    // margin registers
    logic [pcdst_pkg::MARGIN_W-1:0] r_margin_x;
    logic [pcdst_pkg::MARGIN_W-1:0] r_margin_y;

    pcdst_pkg::t_op   op;
    logic [POS_W-1:0] pos;
    logic             rd_en;
    logic [7:0]       rd_data;
    logic             adv;
    logic             clr_busy;
    logic             sh_we;
    logic [POS_W-1:0] sh_wa;
    logic [7:0]       sh_wd;

    // config is always accepted; the user must only write it while the datapath is idle, unchecked
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_margin_x <= pcdst_pkg::MARGIN_X_RST;
            r_margin_y <= pcdst_pkg::MARGIN_Y_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pcdst_pkg::CFG_MARGIN_X: r_margin_x <= i_cfg_data;
                pcdst_pkg::CFG_MARGIN_Y: r_margin_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // front: pan on frame start, crop position and funnel shift on pixel bytes,
    // issues shadow reads; a second crop byte at row end is registered and goes out after the first
    pcdst_front #(
        .CROP_WIDTH    (CROP_WIDTH),
        .CROP_HEIGHT   (CROP_HEIGHT),
        .SOURCE_WIDTH  (SOURCE_WIDTH),
        .SOURCE_HEIGHT (SOURCE_HEIGHT),
        .STRIP_HEIGHT  (STRIP_HEIGHT),
        .POS_W         (POS_W)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_pointer_x  (i_pointer_x),
        .i_pointer_y  (i_pointer_y),
        .i_pixel_byte (i_pixel_byte),
        .i_src_row    (i_src_row),
        .i_src_col    (i_src_col),
        .i_margin_x   (r_margin_x),
        .i_margin_y   (r_margin_y),
        .i_adv        (adv),
        .i_clr_busy   (clr_busy),
        .o_op         (op),
        .o_pos        (pos),
        .o_rd_en      (rd_en)
    );

    // shadow memory: read in the front cycle, written back in the commit cycle,
    // with a bypass when both touch the same entry
    pcdst_shadow #(
        .DEPTH  (SHADOW_DEPTH),
        .ADDR_W (POS_W)
    ) u_shadow (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (rd_en),
        .i_rd_addr  (pos),
        .o_rd_data  (rd_data),
        .i_wr_en    (sh_we),
        .i_wr_addr  (sh_wa),
        .i_wr_data  (sh_wd),
        .o_clr_busy (clr_busy)
    );

    // commit: compare, write back, strip accumulation and the result register
    pcdst_commit #(
        .CROP_HEIGHT  (CROP_HEIGHT),
        .STRIP_HEIGHT (STRIP_HEIGHT),
        .POS_W        (POS_W)
    ) u_commit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_op         (op),
        .i_pos        (pos),
        .i_rd_data    (rd_data),
        .o_adv        (adv),
        .o_wr_en      (sh_we),
        .o_wr_addr    (sh_wa),
        .o_wr_data    (sh_wd),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kind       (o_kind),
        .o_view_x     (o_view_x),
        .o_view_y     (o_view_y),
        .o_dirty_mask (o_dirty_mask)
    );

    // no input item enters and no result leaves while the shadow is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> (!o_in_ready && !o_out_valid))
        else $error("transfer activity during shadow clearing pass");

    // the datapath never writes the shadow while it is being cleared
    a_no_write_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !sh_we)
        else $error("shadow write during clearing pass");

    // a view report carries no strip bits
    a_view_mask_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_kind == pcdst_pkg::KIND_VIEW)) |-> (o_dirty_mask == '0))
        else $error("view report with nonzero dirty mask");

endmodule
